>>> rtl/bmpg_pkg.sv
// Shared types and constants for the 24-bit bitmap to gray stream decoder.
// No dependencies; every other file in rtl imports this package.
package bmpg_pkg;

	localparam int DIM_W = 13;
	localparam int IDX_W = 12;
	localparam int SUM_W = 10;
	localparam int HCNT_W = 6;

	localparam logic [1:0] KIND_PIXEL = 2'd0;
	localparam logic [1:0] KIND_ACCEPT = 2'd1;
	localparam logic [1:0] KIND_NOT_BMP = 2'd2;
	localparam logic [1:0] KIND_UNSUPPORTED = 2'd3;

	// header byte positions
	localparam logic [HCNT_W-1:0] POS_SIG0 = 6'd0;
	localparam logic [HCNT_W-1:0] POS_SIG1 = 6'd1;
	localparam logic [HCNT_W-1:0] POS_W0 = 6'd18;
	localparam logic [HCNT_W-1:0] POS_W1 = 6'd19;
	localparam logic [HCNT_W-1:0] POS_W2 = 6'd20;
	localparam logic [HCNT_W-1:0] POS_W3 = 6'd21;
	localparam logic [HCNT_W-1:0] POS_H0 = 6'd22;
	localparam logic [HCNT_W-1:0] POS_H1 = 6'd23;
	localparam logic [HCNT_W-1:0] POS_H2 = 6'd24;
	localparam logic [HCNT_W-1:0] POS_H3 = 6'd25;
	localparam logic [HCNT_W-1:0] POS_D0 = 6'd28;
	localparam logic [HCNT_W-1:0] POS_D1 = 6'd29;
	localparam logic [HCNT_W-1:0] POS_C0 = 6'd30;
	localparam logic [HCNT_W-1:0] POS_C1 = 6'd31;
	localparam logic [HCNT_W-1:0] POS_C2 = 6'd32;
	localparam logic [HCNT_W-1:0] POS_C3 = 6'd33;
	localparam logic [HCNT_W-1:0] POS_LAST = 6'd53;

	localparam logic [7:0] SIG_B = 8'h42;
	localparam logic [7:0] SIG_M = 8'h4D;
	localparam logic [7:0] DEPTH_24 = 8'd24;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_file;
	} file_beat_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [SUM_W-1:0] gray_sum;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] column;
		logic [DIM_W-1:0] image_width;
		logic [DIM_W-1:0] image_height;
		logic             last_pixel;
	} gray_beat_t;

	// verdict of the header parser, shown on the last header byte
	typedef struct packed {
		logic             done;
		logic [1:0]       kind;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
	} hdr_res_t;

endpackage

>>> rtl/bmpg_hdr.sv
// Header parser: walks the 54 header bytes, keeps the fields that matter
// and gives the verdict on the last one. Depends on bmpg_pkg.
module bmpg_hdr import bmpg_pkg::*; #(
	parameter int MAX_DIM = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid,
	input  logic       step,
	input  logic       phase_hdr,
	input  file_beat_t beat,
	output hdr_res_t   res
);

	logic [HCNT_W-1:0] cnt_q;
	logic              sig_q;
	logic [DIM_W-1:0]  w_lo_q;
	logic              w_hi_q;
	logic [DIM_W-1:0]  h_lo_q;
	logic              h_hi_q;
	logic              d_lo_ok_q;
	logic              d_hi_ok_q;
	logic              comp_nz_q;

	logic              active;
	logic [HCNT_W-1:0] pos;
	logic [7:0]        b;
	logic              w_ok;
	logic              h_ok;
	logic [DIM_W-1:0]  max_dim;

	assign b       = beat.data_byte;
	assign active  = beat.start_of_file || phase_hdr;
	assign pos     = beat.start_of_file ? '0 : cnt_q;
	assign max_dim = DIM_W'(MAX_DIM);

	// a dimension is fine when bits above the kept 13 are clear and 1..MAX_DIM
	assign w_ok = !w_hi_q && (w_lo_q != '0) && (w_lo_q <= max_dim);
	assign h_ok = !h_hi_q && (h_lo_q != '0) && (h_lo_q <= max_dim);

	always_comb begin
		res = '0;
		res.done = valid && active && (pos == POS_LAST);
		if (!sig_q) begin
			res.kind = KIND_NOT_BMP;
		end else if (comp_nz_q || !d_lo_ok_q || !d_hi_ok_q || !w_ok || !h_ok) begin
			res.kind = KIND_UNSUPPORTED;
		end else begin
			res.kind   = KIND_ACCEPT;
			res.width  = w_lo_q;
			res.height = h_lo_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			sig_q     <= 1'b0;
			w_lo_q    <= '0;
			w_hi_q    <= 1'b0;
			h_lo_q    <= '0;
			h_hi_q    <= 1'b0;
			d_lo_ok_q <= 1'b0;
			d_hi_ok_q <= 1'b0;
			comp_nz_q <= 1'b0;
		end else if (step && active) begin
			if (beat.start_of_file) begin
				sig_q     <= 1'b0;
				w_lo_q    <= '0;
				w_hi_q    <= 1'b0;
				h_lo_q    <= '0;
				h_hi_q    <= 1'b0;
				d_lo_ok_q <= 1'b0;
				d_hi_ok_q <= 1'b0;
				comp_nz_q <= 1'b0;
			end
			if (pos != POS_LAST) begin
				cnt_q <= pos + HCNT_W'(1);
			end
			case (pos)
				POS_SIG0: sig_q <= (b == SIG_B);
				POS_SIG1: sig_q <= sig_q && (b == SIG_M);
				POS_W0:   w_lo_q[7:0] <= b;
				POS_W1: begin
					w_lo_q[DIM_W-1:8] <= b[DIM_W-9:0];
					w_hi_q            <= (b[7:DIM_W-8] != '0);
				end
				POS_W2, POS_W3: w_hi_q <= w_hi_q || (b != '0);
				POS_H0:   h_lo_q[7:0] <= b;
				POS_H1: begin
					h_lo_q[DIM_W-1:8] <= b[DIM_W-9:0];
					h_hi_q            <= (b[7:DIM_W-8] != '0);
				end
				POS_H2, POS_H3: h_hi_q <= h_hi_q || (b != '0);
				POS_D0:   d_lo_ok_q <= (b == DEPTH_24);
				POS_D1:   d_hi_ok_q <= (b == '0);
				POS_C0, POS_C1, POS_C2, POS_C3: comp_nz_q <= comp_nz_q || (b != '0);
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/bmpg_pix.sv
// Pixel walker: holds the parse phase, sums colour triples, tracks row and
// column, skips row padding and builds the result beat. Depends on bmpg_pkg.
module bmpg_pix import bmpg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid,
	input  logic       step,
	input  file_beat_t beat,
	input  hdr_res_t   hdr,
	output logic       phase_hdr,
	output logic       res_valid,
	output gray_beat_t res
);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_PIXELS,
		PH_IDLE
	} phase_t;

	phase_t           phase_q;
	logic [IDX_W-1:0] row_q;
	logic [IDX_W-1:0] col_q;
	logic [1:0]       cc_q;
	logic [SUM_W-1:0] psum_q;
	logic [1:0]       pad_q;
	logic [DIM_W-1:0] width_q;

	logic             in_pixels;
	logic             pix_live;
	logic [SUM_W-1:0] sum_next;
	logic [DIM_W-1:0] col_inc;
	logic             row_end;
	logic             last;

	assign phase_hdr = (phase_q == PH_HEADER);
	assign in_pixels = !beat.start_of_file && (phase_q == PH_PIXELS);
	assign pix_live  = valid && in_pixels && (pad_q == '0) && (cc_q == 2'd2);
	assign sum_next  = psum_q + SUM_W'(beat.data_byte);
	assign col_inc   = {1'b0, col_q} + DIM_W'(1);
	assign row_end   = (col_inc >= width_q);
	assign last      = row_end && (row_q == '0);

	always_comb begin
		res       = '0;
		res_valid = 1'b0;
		if (hdr.done) begin
			res_valid        = 1'b1;
			res.kind         = hdr.kind;
			res.image_width  = hdr.width;
			res.image_height = hdr.height;
		end else if (pix_live) begin
			res_valid      = 1'b1;
			res.kind       = KIND_PIXEL;
			res.gray_sum   = sum_next;
			res.row        = row_q;
			res.column     = col_q;
			res.last_pixel = last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			row_q   <= '0;
			col_q   <= '0;
			cc_q    <= '0;
			psum_q  <= '0;
			pad_q   <= '0;
			width_q <= '0;
		end else if (step) begin
			if (hdr.done) begin
				if (hdr.kind == KIND_ACCEPT) begin
					phase_q <= PH_PIXELS;
					row_q   <= IDX_W'(hdr.height - DIM_W'(1));
					col_q   <= '0;
					cc_q    <= '0;
					psum_q  <= '0;
					pad_q   <= '0;
					width_q <= hdr.width;
				end else begin
					phase_q <= PH_IDLE;
				end
			end else if (beat.start_of_file) begin
				phase_q <= PH_HEADER;
			end else if (in_pixels) begin
				if (pad_q != '0) begin
					pad_q <= pad_q - 2'd1;
				end else if (cc_q != 2'd2) begin
					cc_q   <= cc_q + 2'd1;
					psum_q <= sum_next;
				end else begin
					cc_q   <= '0;
					psum_q <= '0;
					if (last) begin
						phase_q <= PH_IDLE;
					end else if (row_end) begin
						row_q <= row_q - IDX_W'(1);
						col_q <= '0;
						// padding to a 4-byte row equals width mod 4 for 3-byte pixels
						pad_q <= width_q[1:0];
					end else begin
						col_q <= col_inc[IDX_W-1:0];
					end
				end
			end
		end
	end

endmodule

>>> rtl/bmp24_stream_to_gray.sv
// Pipeline: a byte passes the input register and then the result register;
// a stall on the result side can hold it in the input register.
// Throughput: one byte per cycle while the result side does not stall;
// a byte that gives no result never waits on the result side.
// Reset: arst_n clears all control state; the parse restarts at header byte 0.
// Depends on bmpg_pkg, bmpg_hdr and bmpg_pix.
module bmp24_stream_to_gray import bmpg_pkg::*; #(
	parameter int MAX_DIM = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       file_valid,
	output logic       file_stall,
	input  file_beat_t file_beat,
	output logic       gray_valid,
	input  logic       gray_stall,
	output gray_beat_t gray_beat
);

	logic       beat_valid_s1;
	file_beat_t beat_s1;
	logic       out_valid_q;
	gray_beat_t out_q;

	hdr_res_t   hdr;
	logic       phase_hdr;
	logic       res_valid;
	gray_beat_t res;
	logic       out_free;
	logic       go;

	assign out_free   = !out_valid_q || !gray_stall;
	assign go         = beat_valid_s1 && (!res_valid || out_free);
	assign file_stall = beat_valid_s1 && !go;
	assign gray_valid = out_valid_q;
	assign gray_beat  = out_q;

	bmpg_hdr #(
		.MAX_DIM(MAX_DIM)
	) u_hdr (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (beat_valid_s1),
		.step     (go),
		.phase_hdr(phase_hdr),
		.beat     (beat_s1),
		.res      (hdr)
	);

	bmpg_pix u_pix (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (beat_valid_s1),
		.step     (go),
		.beat     (beat_s1),
		.hdr      (hdr),
		.phase_hdr(phase_hdr),
		.res_valid(res_valid),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_valid_s1 <= 1'b0;
			beat_s1       <= '0;
			out_valid_q   <= 1'b0;
			out_q         <= '0;
		end else begin
			// take a new beat whenever the input stage is empty or moving on
			if (!file_stall) begin
				beat_valid_s1 <= file_valid;
				beat_s1       <= file_beat;
			end
			if (out_free) begin
				out_valid_q <= go && res_valid;
				out_q       <= res;
			end
		end
	end

endmodule
